[hdl/cmg_pkg.sv]
package cmg_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned RowW    = 3;
  localparam int unsigned DayW    = 5;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned Cols    = 7;

  localparam int unsigned YyW     = 15;
  localparam int unsigned Q4W     = 13;
  localparam int unsigned YQ4W    = 12;
  localparam int unsigned Q100W   = 8;
  localparam int unsigned ProdW   = 29;
  localparam int unsigned RecipW  = 16;
  localparam int unsigned RecipSh = 20;
  localparam logic [RecipW-1:0] Recip25 = 16'd41944;

  localparam logic [YyW-1:0] YearBias  = 15'd400;
  localparam logic [YyW-1:0] SumOffset = 15'd168;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] FebShort = 5'd28;
  localparam logic [DayW-1:0] FebLong  = 5'd29;

  localparam logic [DayW-1:0] MonthDays [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // (13 * (mm + 1) / 5) mod 7, January and February as months 13 and 14
  localparam logic [2:0] MonthTerm [16] = '{
    3'd0, 3'd1, 3'd4, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6,
    3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd0, 3'd0, 3'd0
  };

  // Zeller h (0 = Saturday) to weekday 1 = Monday .. 7 = Sunday
  localparam logic [WdayW-1:0] HToWeekday [7] = '{
    3'd6, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
  };

  typedef struct packed {
    logic              mvalid;
    logic [DayW-1:0]   len;
    logic [WdayW-1:0]  first;
    logic [RowW-1:0]   rows;
  } month_info_t;

  function automatic logic [2:0] mod7(input logic [YyW-1:0] x);
    logic [5:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    b = 4'(a[2:0]) + 4'(a[5:3]);
    c = 4'(b[2:0]) + 4'(b[3]);
    if (c >= 4'd7) begin
      c = c - 4'd7;
    end
    return c[2:0];
  endfunction

endpackage

[hdl/cmg_weekday.sv]
module cmg_weekday (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cmg_pkg::YearW-1:0]            year_i,
  input  logic [cmg_pkg::MonthW-1:0]           month_i,
  output logic                                 info_valid_o,
  input  logic                                 info_ready_i,
  output cmg_pkg::month_info_t                 info_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [cmg_pkg::YyW-1:0]    yy1_q, yy2_q;
  logic [2:0]                 t1_q, t2_q;
  logic [cmg_pkg::DayW-1:0]   base1_q, base2_q, len3_q, len4_q;
  logic                       feb1_q, feb2_q;
  logic                       mv1_q, mv2_q, mv3_q, mv4_q;
  logic                       y4_1_q, y4_2_q;
  logic [cmg_pkg::YQ4W-1:0]   yq4_1_q, yq4_2_q;
  logic [cmg_pkg::Q4W-1:0]    q4_2_q;
  logic [cmg_pkg::Q100W-1:0]  q100_2_q, qy100_2_q;
  logic [cmg_pkg::YyW-1:0]    sum3_q;
  logic [cmg_pkg::WdayW-1:0]  first4_q;
  logic [cmg_pkg::RowW-1:0]   rows4_q;

  logic [cmg_pkg::YyW-1:0]    yy1_d;
  logic [cmg_pkg::Q4W-1:0]    q4_1;
  logic [cmg_pkg::ProdW-1:0]  prod_yy, prod_y;
  logic                       div100, leap;
  logic [cmg_pkg::YQ4W-1:0]   rem_chk;
  logic [cmg_pkg::DayW-1:0]   len3_d;
  logic [cmg_pkg::YyW-1:0]    sum3_d;
  logic [2:0]                 h4;
  logic [cmg_pkg::WdayW-1:0]  first4_d;
  logic [5:0]                 span4;
  logic [cmg_pkg::RowW-1:0]   rows4_d;
  logic                       janfeb;

  assign rdy4       = !v4_q || info_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign janfeb = (month_i == cmg_pkg::MonthJan) || (month_i == cmg_pkg::MonthFeb);
  assign yy1_d  = cmg_pkg::YyW'(year_i) + cmg_pkg::YearBias - cmg_pkg::YyW'(janfeb);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      yy1_q   <= yy1_d;
      t1_q    <= cmg_pkg::MonthTerm[month_i];
      base1_q <= cmg_pkg::MonthDays[month_i];
      feb1_q  <= (month_i == cmg_pkg::MonthFeb);
      mv1_q   <= (month_i >= cmg_pkg::MonthJan) && (month_i <= cmg_pkg::MonthDec);
      y4_1_q  <= (year_i[1:0] == 2'b00);
      yq4_1_q <= year_i[cmg_pkg::YearW-1:2];
    end
  end

  assign q4_1    = yy1_q[cmg_pkg::YyW-1:2];
  assign prod_yy = cmg_pkg::ProdW'(q4_1) * cmg_pkg::ProdW'(cmg_pkg::Recip25);
  assign prod_y  = cmg_pkg::ProdW'(yq4_1_q) * cmg_pkg::ProdW'(cmg_pkg::Recip25);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      yy2_q     <= yy1_q;
      t2_q      <= t1_q;
      base2_q   <= base1_q;
      feb2_q    <= feb1_q;
      mv2_q     <= mv1_q;
      y4_2_q    <= y4_1_q;
      yq4_2_q   <= yq4_1_q;
      q4_2_q    <= q4_1;
      q100_2_q  <= prod_yy[cmg_pkg::RecipSh +: cmg_pkg::Q100W];
      qy100_2_q <= prod_y[cmg_pkg::RecipSh +: cmg_pkg::Q100W];
    end
  end

  assign rem_chk = cmg_pkg::YQ4W'(qy100_2_q) * cmg_pkg::YQ4W'(25);
  assign div100  = (rem_chk == yq4_2_q);
  assign leap    = y4_2_q && (!div100 || (qy100_2_q[1:0] == 2'b00));
  assign len3_d  = feb2_q ? (leap ? cmg_pkg::FebLong : cmg_pkg::FebShort) : base2_q;
  assign sum3_d  = cmg_pkg::YyW'(1) + cmg_pkg::YyW'(t2_q) + yy2_q + cmg_pkg::YyW'(q4_2_q)
                 + cmg_pkg::YyW'(q100_2_q[cmg_pkg::Q100W-1:2]) + cmg_pkg::SumOffset
                 - cmg_pkg::YyW'(q100_2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      sum3_q <= sum3_d;
      len3_q <= len3_d;
      mv3_q  <= mv2_q;
    end
  end

  assign h4       = cmg_pkg::mod7(sum3_q);
  assign first4_d = cmg_pkg::HToWeekday[h4];
  assign span4    = 6'(len3_q) + 6'(first4_d) + 6'd5;
  assign rows4_d  = (span4 >= 6'd42) ? 3'd6 : ((span4 >= 6'd35) ? 3'd5 : 3'd4);

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      first4_q <= first4_d;
      rows4_q  <= rows4_d;
      len4_q   <= len3_q;
      mv4_q    <= mv3_q;
    end
  end

  assign info_valid_o = v4_q;
  assign info_o       = '{mvalid: mv4_q, len: len4_q, first: first4_q, rows: rows4_q};

endmodule

[hdl/cmg_row_gen.sv]
module cmg_row_gen (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              info_valid_i,
  output logic                              info_ready_o,
  input  cmg_pkg::month_info_t              info_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cmg_pkg::RowW-1:0]          row_number_o,
  output logic [cmg_pkg::DayW-1:0]          day_mon_o,
  output logic [cmg_pkg::DayW-1:0]          day_tue_o,
  output logic [cmg_pkg::DayW-1:0]          day_wed_o,
  output logic [cmg_pkg::DayW-1:0]          day_thu_o,
  output logic [cmg_pkg::DayW-1:0]          day_fri_o,
  output logic [cmg_pkg::DayW-1:0]          day_sat_o,
  output logic [cmg_pkg::DayW-1:0]          day_sun_o,
  output logic [cmg_pkg::DayW-1:0]          month_length_o,
  output logic [cmg_pkg::WdayW-1:0]         first_weekday_o,
  output logic                              last_row_o
);

  logic                        ev_q, ov_q;
  logic [cmg_pkg::RowW-1:0]    r_q, rows_q;
  logic signed [6:0]           start_q;
  logic [cmg_pkg::DayW-1:0]    len_q;
  logic [cmg_pkg::WdayW-1:0]   first_q;
  logic                        load, last;
  logic [cmg_pkg::DayW-1:0]    day [cmg_pkg::Cols];
  logic [cmg_pkg::DayW-1:0]    day_q [cmg_pkg::Cols];
  logic [cmg_pkg::RowW-1:0]    row_q;
  logic [cmg_pkg::DayW-1:0]    olen_q;
  logic [cmg_pkg::WdayW-1:0]   ofirst_q;
  logic                        olast_q;

  assign last         = (r_q == rows_q);
  assign load         = ev_q && (!ov_q || out_ready_i);
  assign info_ready_o = !ev_q || (load && last);

  always_comb begin
    logic signed [6:0] d;
    for (int c = 0; c < cmg_pkg::Cols; c++) begin
      d = start_q + 7'(c);
      if ((d >= 7'sd1) && (d <= $signed({2'b00, len_q}))) begin
        day[c] = d[cmg_pkg::DayW-1:0];
      end else begin
        day[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (info_ready_o) ev_q <= info_valid_i && info_i.mvalid;
      if (!ov_q || out_ready_i) ov_q <= ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (info_ready_o) begin
      r_q     <= 3'd1;
      start_q <= 7'sd2 - $signed({4'b0000, info_i.first});
      len_q   <= info_i.len;
      first_q <= info_i.first;
      rows_q  <= info_i.rows;
    end else if (load) begin
      r_q     <= r_q + 3'd1;
      start_q <= start_q + 7'sd7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      day_q    <= day;
      row_q    <= r_q;
      olen_q   <= len_q;
      ofirst_q <= first_q;
      olast_q  <= last;
    end
  end

  assign out_valid_o     = ov_q;
  assign row_number_o    = row_q;
  assign day_mon_o       = day_q[0];
  assign day_tue_o       = day_q[1];
  assign day_wed_o       = day_q[2];
  assign day_thu_o       = day_q[3];
  assign day_fri_o       = day_q[4];
  assign day_sat_o       = day_q[5];
  assign day_sun_o       = day_q[6];
  assign month_length_o  = olen_q;
  assign first_weekday_o = ofirst_q;
  assign last_row_o      = olast_q;

  ap_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !last |=> ev_q && (r_q == $past(r_q) + 3'd1))
    else $error("row counter did not advance");

  ap_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_number_o == 3'd1) |-> ((first_weekday_o == 3'd1) == (day_mon_o == 5'd1)))
    else $error("first row misplaced");

  ap_full_week: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_row_o |-> (day_sun_o != 5'd0))
    else $error("non-final row ends with empty Sunday");

  ap_last_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_row_o |-> (day_mon_o != 5'd0)
      && (6'(day_mon_o) + 6'd6 >= 6'(month_length_o)))
    else $error("last row does not hold end of month");

endmodule

[hdl/calendar_month_grid.sv]
// Channel   Direction  Signals
// in        input      in_valid_i, in_ready_o, year_i, month_i
// out       output     out_valid_o, out_ready_i, row_number_o, day_*_o, month_length_o,
//                      first_weekday_o, last_row_o
//
// A request passes four pipeline stages (bias, reciprocal multiply, Zeller sum, mod 7),
// then the row generator emits one week row per cycle while its output is not stalled,
// 4 to 6 rows per request. A new request enters every cycle while the pipeline has room.
// The first row passes the row generator's month register and output register before it is
// valid. A month outside 1..12 yields no rows; the row generator drops it on taking it.
// Reset clears only valid bits. Back-pressure stalls every stage in place.
module calendar_month_grid (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cmg_pkg::YearW-1:0]         year_i,
  input  logic [cmg_pkg::MonthW-1:0]        month_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cmg_pkg::RowW-1:0]          row_number_o,
  output logic [cmg_pkg::DayW-1:0]          day_mon_o,
  output logic [cmg_pkg::DayW-1:0]          day_tue_o,
  output logic [cmg_pkg::DayW-1:0]          day_wed_o,
  output logic [cmg_pkg::DayW-1:0]          day_thu_o,
  output logic [cmg_pkg::DayW-1:0]          day_fri_o,
  output logic [cmg_pkg::DayW-1:0]          day_sat_o,
  output logic [cmg_pkg::DayW-1:0]          day_sun_o,
  output logic [cmg_pkg::DayW-1:0]          month_length_o,
  output logic [cmg_pkg::WdayW-1:0]         first_weekday_o,
  output logic                              last_row_o
);

  logic                 info_valid;
  logic                 info_ready;
  cmg_pkg::month_info_t info;

  cmg_weekday u_weekday (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .year_i       (year_i),
    .month_i      (month_i),
    .info_valid_o (info_valid),
    .info_ready_i (info_ready),
    .info_o       (info)
  );

  cmg_row_gen u_row_gen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .info_valid_i    (info_valid),
    .info_ready_o    (info_ready),
    .info_i          (info),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .row_number_o    (row_number_o),
    .day_mon_o       (day_mon_o),
    .day_tue_o       (day_tue_o),
    .day_wed_o       (day_wed_o),
    .day_thu_o       (day_thu_o),
    .day_fri_o       (day_fri_o),
    .day_sat_o       (day_sat_o),
    .day_sun_o       (day_sun_o),
    .month_length_o  (month_length_o),
    .first_weekday_o (first_weekday_o),
    .last_row_o      (last_row_o)
  );

endmodule

[tb/tb_calendar_month_grid.sv]
`timescale 1ns / 1ps

module tb_calendar_month_grid;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 16;

  localparam int unsigned MonthLen [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [cmg_pkg::RowW-1:0]                   row_number;
    logic [cmg_pkg::Cols-1:0][cmg_pkg::DayW-1:0] day;
    logic [cmg_pkg::DayW-1:0]                   month_length;
    logic [cmg_pkg::WdayW-1:0]                  first_weekday;
    logic                                       last_row;
  } grid_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [cmg_pkg::YearW-1:0]    year_i;
  logic [cmg_pkg::MonthW-1:0]   month_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [cmg_pkg::RowW-1:0]     row_number_o;
  logic [cmg_pkg::DayW-1:0]     day_mon_o;
  logic [cmg_pkg::DayW-1:0]     day_tue_o;
  logic [cmg_pkg::DayW-1:0]     day_wed_o;
  logic [cmg_pkg::DayW-1:0]     day_thu_o;
  logic [cmg_pkg::DayW-1:0]     day_fri_o;
  logic [cmg_pkg::DayW-1:0]     day_sat_o;
  logic [cmg_pkg::DayW-1:0]     day_sun_o;
  logic [cmg_pkg::DayW-1:0]     month_length_o;
  logic [cmg_pkg::WdayW-1:0]    first_weekday_o;
  logic                         last_row_o;

  grid_row_t   expected_rows[$];
  grid_row_t   front_row;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  bit          hold_req = 1'b0;

  calendar_month_grid DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .year_i         (year_i),
    .month_i        (month_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_number_o   (row_number_o),
    .day_mon_o      (day_mon_o),
    .day_tue_o      (day_tue_o),
    .day_wed_o      (day_wed_o),
    .day_thu_o      (day_thu_o),
    .day_fri_o      (day_fri_o),
    .day_sat_o      (day_sat_o),
    .day_sun_o      (day_sun_o),
    .month_length_o (month_length_o),
    .first_weekday_o(first_weekday_o),
    .last_row_o     (last_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void predict_month_grid(input logic [cmg_pkg::YearW-1:0] year,
                                             input logic [cmg_pkg::MonthW-1:0] month);
    int unsigned y, mm, yy, h, len, first, rows, r, c;
    int          start, d;
    grid_row_t   row;
    if (month < cmg_pkg::MonthJan || month > cmg_pkg::MonthDec) return;
    y = 32'(year);
    if (month == cmg_pkg::MonthFeb) begin
      len = ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 29 : 28;
    end else begin
      len = MonthLen[month];
    end
    mm = 32'(month);
    yy = y + 400;
    if (month <= cmg_pkg::MonthFeb) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    h = (1 + (13 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
    first = ((h + 5) % 7) + 1;
    rows = (len + first + 5) / 7;
    for (r = 1; r <= rows; r++) begin
      start = 7 * (int'(r) - 1) + 2 - int'(first);
      row.row_number = r[cmg_pkg::RowW-1:0];
      for (c = 0; c < cmg_pkg::Cols; c++) begin
        d = start + int'(c);
        row.day[c] = (d >= 1 && d <= int'(len)) ? cmg_pkg::DayW'(d) : '0;
      end
      row.month_length  = len[cmg_pkg::DayW-1:0];
      row.first_weekday = first[cmg_pkg::WdayW-1:0];
      row.last_row      = (r == rows);
      expected_rows.push_back(row);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rows.size() == 0) begin
        $error("row_number: expected none, actual %0d", row_number_o);
        mismatches++;
      end else begin
        front_row = expected_rows.pop_front();
        check_field("row_number", 8'(front_row.row_number), 8'(row_number_o));
        check_field("day_mon", 8'(front_row.day[0]), 8'(day_mon_o));
        check_field("day_tue", 8'(front_row.day[1]), 8'(day_tue_o));
        check_field("day_wed", 8'(front_row.day[2]), 8'(day_wed_o));
        check_field("day_thu", 8'(front_row.day[3]), 8'(day_thu_o));
        check_field("day_fri", 8'(front_row.day[4]), 8'(day_fri_o));
        check_field("day_sat", 8'(front_row.day[5]), 8'(day_sat_o));
        check_field("day_sun", 8'(front_row.day[6]), 8'(day_sun_o));
        check_field("month_length", 8'(front_row.month_length), 8'(month_length_o));
        check_field("first_weekday", 8'(front_row.first_weekday), 8'(first_weekday_o));
        check_field("last_row", 8'(front_row.last_row), 8'(last_row_o));
      end
    end
  end

  initial begin : row_receiver
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_stalls) begin
        stall = $urandom_range(0, 19);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && !hold_req);
    end
  end

  task automatic send_month(input logic [cmg_pkg::YearW-1:0] year,
                            input logic [cmg_pkg::MonthW-1:0] month);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    year_i     <= year;
    month_i    <= month;
    do @(posedge clk_i); while (!in_ready_o);
    predict_month_grid(year, month);
  endtask

  task automatic send_random(output bit valid_month);
    logic [cmg_pkg::YearW-1:0]  year;
    logic [cmg_pkg::MonthW-1:0] month;
    int unsigned                pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      month = (pick < 2) ? '0 : cmg_pkg::MonthW'(cmg_pkg::MonthDec + $urandom_range(1, 3));
    end else begin
      month = cmg_pkg::MonthW'($urandom_range(cmg_pkg::MonthJan, cmg_pkg::MonthDec));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      year = cmg_pkg::YearW'($urandom_range(1, 9999));
    end else if (pick < 8) begin
      year = cmg_pkg::YearW'($urandom_range(0, 16383));
    end else begin
      year = cmg_pkg::YearW'(100 * $urandom_range(0, 163));
    end
    valid_month = (month >= cmg_pkg::MonthJan && month <= cmg_pkg::MonthDec);
    send_month(year, month);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_months(input int unsigned count);
    int unsigned sent;
    bit          counted;
    sent = 0;
    while (sent < count) begin
      send_random(counted);
      if (counted) sent++;
    end
  endtask

  task automatic test_directed();
    int unsigned m;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_month(1, cmg_pkg::MonthJan);
    send_month(9999, cmg_pkg::MonthDec);
    send_month(0, cmg_pkg::MonthJan);
    send_month(0, cmg_pkg::MonthFeb);
    send_month(16383, cmg_pkg::MonthJan);
    send_month(16383, cmg_pkg::MonthDec);
    send_month(2000, cmg_pkg::MonthFeb);
    send_month(1900, cmg_pkg::MonthFeb);
    send_month(2021, cmg_pkg::MonthFeb);
    send_month(10000, cmg_pkg::MonthFeb);
    send_month(2024, 4'd0);
    send_month(2024, cmg_pkg::MonthDec + 4'd1);
    send_month(2024, 4'hF);
    for (m = 32'(cmg_pkg::MonthJan); m <= 32'(cmg_pkg::MonthDec); m++) begin
      send_month(2021, cmg_pkg::MonthW'(m));
    end
    wait_for_drain();
  endtask

  task automatic test_back_to_back();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_random_months(60);
    wait_for_drain();
  endtask

  task automatic test_random_idle();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_random_months(240);
    wait_for_drain();
  endtask

  task automatic test_output_hold();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_req  = 1'b1;
    send_random_months(40);
    wait_for_drain();
  endtask

  task automatic test_pause_until_drained();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_random_months(30);
    wait_for_drain();
    tx_gaps = 1'b0;
    send_random_months(30);
    wait_for_drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    year_i     = '0;
    month_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_back_to_back();
    test_random_idle();
    test_output_hold();
    test_pause_until_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
